// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// SLIP frame receiver package
// Shared types, codes and constants for the SLIP frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH          = 2;
   localparam int LEN_W                = 7;

   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
   localparam logic [16:0] IDLE_MAX      = 17'h1ffff;

   localparam logic [7:0] END_BYTE = 8'hc0;
   localparam logic [7:0] ESC_BYTE = 8'hdb;
   localparam logic [7:0] ESC_END  = 8'hdc;
   localparam logic [7:0] ESC_ESC  = 8'hdd;

   localparam logic [1:0] CMD_BYTE     = 2'd0;
   localparam logic [1:0] CMD_TICK     = 2'd1;
   localparam logic [1:0] CMD_DISPATCH = 2'd2;

   localparam logic [2:0] STAT_NONE     = 3'd0;
   localparam logic [2:0] STAT_OK       = 3'd1;
   localparam logic [2:0] STAT_MSG_OVF  = 3'd2;
   localparam logic [2:0] STAT_DATA_OVF = 3'd3;
   localparam logic [2:0] STAT_TIMEOUT  = 3'd4;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic             has_data;
      logic [7:0]       data_byte_out;
      logic [LEN_W-1:0] message_length;
      logic             last;
      logic [2:0]       status;
   } rsp_type;

   // One dispatch outcome handed from the front end to the streaming back end.
   typedef struct packed {
      logic             stream;
      logic [2:0]       status;
      logic [LEN_W-1:0] length;
   } job_type;

endpackage

// ===== rtl/sfr_front.sv =====
// ----------------------------------------------------------------------------
// SLIP frame receiver front end
// Accepts items, runs the framing state machine, writes decoded bytes to the
// message store and turns dispatch requests into jobs for the back end.
// ----------------------------------------------------------------------------
module sfr_front
   import sfr_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT,
   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1,
   localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   input  logic              csr_wr_en,
   input  logic [15:0]       csr_wr_data,
   input  logic              q_empty,
   input  logic              q_full,
   output logic              q_push,
   output job_type           q_job,
   output logic              mem_wr_en,
   output logic [ADDR_W-1:0] mem_wr_addr,
   output logic [7:0]        mem_wr_data
);

   localparam logic [2:0] FS_WAIT     = 3'd0;
   localparam logic [2:0] FS_DATA     = 3'd1;
   localparam logic [2:0] FS_ESC      = 3'd2;
   localparam logic [2:0] FS_AVAIL    = 3'd3;
   localparam logic [2:0] FS_MSG_OVF  = 3'd4;
   localparam logic [2:0] FS_DATA_OVF = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [16:0]      idle_ff, idle_in;
   logic [15:0]      timeout_ff, timeout_in;

   logic       accept;
   logic       store_req;
   logic [7:0] store_val;

   // Bytes wait while a job is queued so a pending message is not overwritten.
   assign req_stall = ((req_data.cmd == CMD_BYTE) && !q_empty) ||
                      ((req_data.cmd == CMD_DISPATCH) && q_full);
   assign accept    = req_valid && !req_stall;

   assign timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      idle_in     = idle_ff;
      store_req   = 1'b0;
      store_val   = req_data.data_byte;
      q_push      = 1'b0;
      q_job       = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = count_ff[ADDR_W-1:0];
      mem_wr_data = store_val;

      if (accept) begin
         unique case (req_data.cmd)
            CMD_BYTE: begin
               idle_in = '0;
               unique case (state_ff)
                  FS_WAIT: begin
                     if (req_data.data_byte == END_BYTE) begin
                        count_in = '0;
                        state_in = FS_DATA;
                     end
                  end
                  FS_DATA: begin
                     if (req_data.data_byte == END_BYTE) begin
                        state_in = (count_ff != '0) ? FS_AVAIL : FS_WAIT;
                     end else if (req_data.data_byte == ESC_BYTE) begin
                        state_in = FS_ESC;
                     end else begin
                        store_req = 1'b1;
                     end
                  end
                  FS_ESC: begin
                     if (req_data.data_byte == ESC_END) begin
                        store_req = 1'b1;
                        store_val = END_BYTE;
                     end else if (req_data.data_byte == ESC_ESC) begin
                        store_req = 1'b1;
                        store_val = ESC_BYTE;
                     end else begin
                        state_in = FS_WAIT;
                     end
                  end
                  FS_AVAIL: begin
                     state_in = FS_MSG_OVF;
                  end
                  default: begin
                  end
               endcase
               if (store_req) begin
                  if (count_ff < CNT_W'(BUFFER_DEPTH)) begin
                     mem_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                     state_in  = FS_DATA;
                  end else begin
                     state_in = FS_DATA_OVF;
                  end
               end
               mem_wr_data = store_val;
            end
            CMD_TICK: begin
               if (idle_ff != IDLE_MAX) begin
                  idle_in = idle_ff + 17'd1;
               end
            end
            CMD_DISPATCH: begin
               q_push = 1'b1;
               if ((state_ff == FS_AVAIL) || (state_ff == FS_MSG_OVF)) begin
                  q_job.stream = 1'b1;
                  q_job.status = (state_ff == FS_MSG_OVF) ? STAT_MSG_OVF : STAT_OK;
                  q_job.length = LEN_W'(count_ff);
                  state_in     = FS_WAIT;
               end else if (state_ff == FS_DATA_OVF) begin
                  q_job.status = STAT_DATA_OVF;
                  state_in     = FS_WAIT;
               end else if (((state_ff == FS_DATA) || (state_ff == FS_ESC)) &&
                            (idle_ff > {1'b0, timeout_ff})) begin
                  q_job.status = STAT_TIMEOUT;
                  state_in     = FS_WAIT;
               end else begin
                  q_job.status = STAT_NONE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FS_WAIT;
         count_ff   <= '0;
         idle_ff    <= '0;
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         idle_ff    <= idle_in;
         timeout_ff <= timeout_in;
      end
   end

endmodule

// ===== rtl/sfr_queue.sv =====
// ----------------------------------------------------------------------------
// SLIP frame receiver job queue
// A short first-in first-out queue of dispatch jobs between front and back.
// ----------------------------------------------------------------------------
module sfr_queue
   import sfr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output job_type head_job,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/sfr_back.sv =====
// ----------------------------------------------------------------------------
// SLIP frame receiver back end
// Holds the message store and turns queued jobs into result transfers, one
// per cycle when not stalled, through a read stage and an output register.
// ----------------------------------------------------------------------------
module sfr_back
   import sfr_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT,
   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              mem_wr_en,
   input  logic [ADDR_W-1:0] mem_wr_addr,
   input  logic [7:0]        mem_wr_data,
   input  job_type           head_job,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data
);

   logic [7:0]        store_mem [BUFFER_DEPTH];
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              rd_valid_ff, rd_valid_in;
   rsp_type           rd_meta_ff;
   logic [7:0]        rd_byte_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_data_ff, out_data_in;

   logic    move;
   logic    issue;
   logic    streaming;
   logic    is_last;
   rsp_type issue_meta;

   assign move      = rd_valid_ff && (!out_valid_ff || !rsp_stall);
   assign issue     = !q_empty && (!rd_valid_ff || move);
   assign streaming = head_job.stream && (head_job.length != '0);
   assign is_last   = !streaming || ((LEN_W'(idx_ff) + LEN_W'(1)) == head_job.length);
   assign q_pop     = issue && is_last;

   always_comb begin
      issue_meta                = '0;
      issue_meta.has_data       = streaming;
      issue_meta.message_length = streaming ? head_job.length : '0;
      issue_meta.last           = is_last;
      issue_meta.status         = head_job.status;

      idx_in = idx_ff;
      if (issue) begin
         idx_in = is_last ? '0 : idx_ff + ADDR_W'(1);
      end

      out_data_in               = rd_meta_ff;
      out_data_in.data_byte_out = rd_meta_ff.has_data ? rd_byte_ff : 8'd0;

      rd_valid_in  = issue || (rd_valid_ff && !move);
      out_valid_in = move || (out_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         store_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (issue) begin
         rd_byte_ff <= store_mem[idx_ff];
         rd_meta_ff <= issue_meta;
      end
      if (move) begin
         out_data_ff <= out_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== rtl/slip_frame_receiver_top.sv =====
// ----------------------------------------------------------------------------
// SLIP frame receiver
// Deframes a SLIP-style byte stream into a message store and streams the
// stored message, or a status, out on each dispatch request.
// ----------------------------------------------------------------------------
// Ticks are never stalled; a byte stalls while a dispatch job is still
// queued, since the job's message store reads must be issued first.
// A dispatch's first result passes through the job queue register, the
// registered message store read and the output register; a message then
// streams one result per cycle while the result channel does not stall.
// Synchronous reset clears all control state, sets the timeout to 1000
// ticks and needs no clearing pass; the message store is not cleared.
module slip_frame_receiver_top
   import sfr_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   // Job queue between the framing front end and the streaming back end.
   logic    q_push;
   logic    q_pop;
   logic    q_empty;
   logic    q_full;
   job_type q_push_job;
   job_type q_head_job;

   // Message store write port, driven by the front end.
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [7:0]        mem_wr_data;

   // The front end owns framing state, the byte count, the idle counter and
   // the timeout register. Every dispatch becomes exactly one job.
   sfr_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .q_empty     (q_empty),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_push_job),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // The queue lets ticks, and dispatches until it is full, keep flowing
   // while the back end waits on a stalled result channel.
   sfr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   // The back end reads the store and drives each result transfer.
   sfr_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .head_job    (q_head_job),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
